// File: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int unsigned DEF_SYMBOL_COUNT = 256;
  localparam int unsigned DEF_WORD_WIDTH   = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CODE_W   = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned BYTES_W  = 4;
  localparam int unsigned PAD_W    = 4;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

// File: hw/rtl/hcbp_if.sv
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SYMBOL_W-1:0] symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_W-1:0]    code_length;

  modport source (output valid, output operation, output symbol, output code_bits,
                  output code_length, input ready);
  modport sink   (input valid, input operation, input symbol, input code_bits,
                  input code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  packed_word;
  logic [BYTES_W-1:0] byte_count;
  logic [PAD_W-1:0]   pad_bits;
  logic               is_final;

  modport source (output valid, output packed_word, output byte_count, output pad_bits,
                  output is_final, input ready);
  modport sink   (input valid, input packed_word, input byte_count, input pad_bits,
                  input is_final, output ready);
endinterface

// File: hw/rtl/hcbp_code_table.sv
module hcbp_code_table #(
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] wr_addr_i,
  input  hcbp_pkg::entry_t                wr_entry_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr_i,
  output hcbp_pkg::entry_t                rd_entry_o
);
  import hcbp_pkg::*;

  entry_t mem [SYMBOL_COUNT];
  entry_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// File: hw/rtl/huffman_code_bit_packer.sv
// Channel  Dir  Modport  Payload
// in_i     in   sink     operation, symbol, code_bits, code_length
// out_o    out  source   packed_word, byte_count, pad_bits, is_final
//
// One beat per cycle on in_i unless the pack stage stalls. An item goes to out_o
// through the code table read, which registers the entry, then the pack step, which
// updates the accumulator and loads the output register.
// rst_ni clears the pipeline valids, the accumulator and the fill count; the
// code table holds garbage until loaded.
// A stalled out_o holds the output register; the pack stage and in_i stall
// only when that stage holds a word to emit.
module huffman_code_bit_packer #(
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT,
  parameter int unsigned WORD_WIDTH   = hcbp_pkg::DEF_WORD_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbp_in_if.sink           in_i,
  hcbp_out_if.source        out_o
);
  import hcbp_pkg::*;

  localparam int unsigned AW         = $clog2(SYMBOL_COUNT);
  localparam int unsigned FW         = $clog2(WORD_WIDTH);
  localparam int unsigned TW         = FW + 1;
  localparam int unsigned FULL_BYTES = (WORD_WIDTH + 7) / 8;
  localparam int unsigned FULL_PAD   = FULL_BYTES * 8 - WORD_WIDTH;

  logic                  in_fire;
  logic                  sym_ok;
  entry_t                wr_entry;
  entry_t                rd_entry;

  logic                  s1_valid_q;
  logic [OP_W-1:0]       s1_op_q;
  logic                  s1_sym_ok_q;
  logic                  s1_adv;

  logic [WORD_WIDTH-1:0] acc_q, acc_d;
  logic [FW-1:0]         fill_q, fill_d;

  logic                  out_valid_q, out_valid_d;
  logic [CODE_W-1:0]     word_q, word_d;
  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic [PAD_W-1:0]      pad_q, pad_d;
  logic                  final_q, final_d;

  logic [LEN_W-1:0]      len_raw;
  logic [TW-1:0]         len_c;
  logic [CODE_W-1:0]     code_msk;
  logic [WORD_WIDTH-1:0] cw;
  logic [WORD_WIDTH-1:0] acc_or;
  logic [WORD_WIDTH-1:0] carry;
  logic [TW-1:0]         total;
  logic                  wrap;
  logic [LEN_W-1:0]      fill_ext;
  logic [LEN_W-1:0]      junk_m1;
  logic [2:0]            full_junk;
  logic [LEN_W-1:0]      flush_pad;
  logic                  emit;

  assign sym_ok  = {1'b0, in_i.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
  assign in_fire = in_i.valid && in_i.ready;

  assign wr_entry.code = in_i.code_bits;
  assign wr_entry.len  = in_i.code_length;

  hcbp_code_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (in_fire && in_i.operation == OP_LOAD && sym_ok),
    .wr_addr_i  (in_i.symbol[AW-1:0]),
    .wr_entry_i (wr_entry),
    .rd_en_i    (in_fire),
    .rd_addr_i  (in_i.symbol[AW-1:0]),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    len_raw   = s1_sym_ok_q ? rd_entry.len : '0;
    len_c     = (len_raw > LEN_W'(WORD_WIDTH)) ? TW'(WORD_WIDTH) : TW'(len_raw);
    code_msk  = rd_entry.code & ~({CODE_W{1'b1}} >> len_c);
    cw        = code_msk[CODE_W-1 -: WORD_WIDTH];
    acc_or    = acc_q | (cw >> fill_q);
    total     = TW'(fill_q) + len_c;
    wrap      = total >= TW'(WORD_WIDTH);
    carry     = (fill_q == '0) ? '0 : (cw << (TW'(WORD_WIDTH) - TW'(fill_q)));
    fill_ext  = LEN_W'(fill_q);
    junk_m1   = LEN_W'(63) - fill_ext;
    full_junk = junk_m1[5:3];
    flush_pad = LEN_W'(64) - fill_ext - {1'b0, full_junk, 3'b000};

    emit = 1'b0;
    case (s1_op_q)
      OP_ENCODE: emit = (len_c != '0) && wrap;
      OP_FLUSH:  emit = 1'b1;
      default:   emit = 1'b0;
    endcase
  end

  assign s1_adv     = s1_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    acc_d       = acc_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_o.ready;
    word_d      = word_q;
    bytes_d     = bytes_q;
    pad_d       = pad_q;
    final_d     = final_q;
    if (s1_adv) begin
      case (s1_op_q)
        OP_ENCODE: begin
          if (len_c != '0) begin
            if (wrap) begin
              out_valid_d = 1'b1;
              word_d      = CODE_W'(acc_or) << (CODE_W - WORD_WIDTH);
              bytes_d     = BYTES_W'(FULL_BYTES);
              pad_d       = PAD_W'(FULL_PAD);
              final_d     = 1'b0;
              acc_d       = carry;
              fill_d      = FW'(total - TW'(WORD_WIDTH));
            end else begin
              acc_d  = acc_or;
              fill_d = FW'(total);
            end
          end
        end
        OP_FLUSH: begin
          out_valid_d = 1'b1;
          word_d      = CODE_W'(acc_q) << (CODE_W - WORD_WIDTH);
          bytes_d     = BYTES_W'(8) - BYTES_W'(full_junk);
          pad_d       = flush_pad[PAD_W-1:0];
          final_d     = 1'b1;
          acc_d       = '0;
          fill_d      = '0;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      fill_q      <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= in_i.operation;
      s1_sym_ok_q <= sym_ok;
    end
    word_q  <= word_d;
    bytes_q <= bytes_d;
    pad_q   <= pad_d;
    final_q <= final_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_word = word_q;
  assign out_o.byte_count  = bytes_q;
  assign out_o.pad_bits    = pad_q;
  assign out_o.is_final    = final_q;

endmodule

// File: tb/tb_huffman_code_bit_packer.sv
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_PER_MODE = 240;

  typedef struct {
    logic [OP_W-1:0]     operation;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_length;
    int unsigned         mode;
    bit                  drain_first;
  } symbol_beat_t;

  typedef struct {
    logic [CODE_W-1:0]  packed_word;
    logic [BYTES_W-1:0] byte_count;
    logic [PAD_W-1:0]   pad_bits;
    logic               is_final;
  } packed_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  symbol_beat_t pending_beats[$];
  packed_word_t expected_words[$];
  symbol_beat_t in_beat;

  logic [CODE_W-1:0] code_mem [256];
  logic [LEN_W-1:0]  len_mem [256];
  logic [CODE_W-1:0] acc_word;
  int unsigned       fill_bits;

  bit              loaded_map [256];
  logic [7:0]      loaded_syms[$];
  int unsigned     gen_mode;
  bit              drain_next;
  int unsigned     beats_queued;
  int unsigned     traffic_mode;

  int unsigned beats_in;
  int unsigned loads_in;
  int unsigned encodes_in;
  int unsigned flushes_in;
  int unsigned words_seen;
  int unsigned finals_seen;
  int unsigned errors;
  int unsigned idle_cycles;

  function automatic int unsigned sender_gap_pct(int unsigned mode);
    case (mode)
      0:       return 18;
      1:       return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(int unsigned mode);
    case (mode)
      0:       return 67;
      1:       return 18;
      default: return 0;
    endcase
  endfunction

  function automatic void pack_beat(symbol_beat_t b);
    logic [CODE_W-1:0] code;
    int unsigned len;
    int unsigned total;
    int unsigned junk;
    int unsigned full_junk;
    packed_word_t w;
    case (b.operation)
      OP_LOAD: begin
        code_mem[b.symbol] = b.code_bits;
        len_mem[b.symbol]  = b.code_length;
      end
      OP_ENCODE: begin
        len = len_mem[b.symbol];
        if (len > 64) len = 64;
        if (len != 0) begin
          code = code_mem[b.symbol] & (~64'd0 << (64 - len));
          acc_word = acc_word | (code >> fill_bits);
          total = fill_bits + len;
          if (total < 64) begin
            fill_bits = total;
          end else begin
            w.packed_word = acc_word;
            w.byte_count  = 4'd8;
            w.pad_bits    = 4'd0;
            w.is_final    = 1'b0;
            expected_words.push_back(w);
            acc_word  = (fill_bits == 0) ? 64'd0 : (code << (64 - fill_bits));
            fill_bits = total - 64;
          end
        end
      end
      OP_FLUSH: begin
        junk = 64 - fill_bits;
        full_junk = (junk - 1) / 8;
        w.packed_word = acc_word;
        w.byte_count  = 4'(8 - full_junk);
        w.pad_bits    = 4'(junk - 8 * full_junk);
        w.is_final    = 1'b1;
        expected_words.push_back(w);
        acc_word  = 64'd0;
        fill_bits = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic push_beat(logic [OP_W-1:0] op, logic [7:0] sym, logic [63:0] code,
                           logic [6:0] len);
    symbol_beat_t b;
    b.operation   = op;
    b.symbol      = sym;
    b.code_bits   = code;
    b.code_length = len;
    b.mode        = gen_mode;
    b.drain_first = drain_next;
    drain_next = 1'b0;
    pending_beats.push_back(b);
    beats_queued++;
    if (op == OP_LOAD && !loaded_map[sym]) begin
      loaded_map[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  function automatic logic [6:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 7'd0;
    if (r < 10) return 7'd64;
    if (r < 15) return 7'($urandom_range(127, 65));
    if (r < 30) return 7'($urandom_range(63, 17));
    return 7'($urandom_range(16, 1));
  endfunction

  task automatic add_random_beats(int unsigned count);
    int unsigned pick;
    logic [7:0] sym;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10 || loaded_syms.size() == 0) begin
        sym = 8'($urandom_range(255));
        push_beat(OP_LOAD, sym, {$urandom, $urandom}, pick_length());
        if ($urandom_range(1) == 1) push_beat(OP_ENCODE, sym, {$urandom, $urandom}, 7'($urandom));
      end else if (pick < 15) begin
        push_beat(OP_FLUSH, 8'($urandom), {$urandom, $urandom}, 7'($urandom));
      end else begin
        sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        push_beat(OP_ENCODE, sym, {$urandom, $urandom}, 7'($urandom));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.operation   <= OP_LOAD;
      in_if.symbol      <= '0;
      in_if.code_bits   <= '0;
      in_if.code_length <= '0;
      traffic_mode      <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pack_beat(in_beat);
        case (in_beat.operation)
          OP_LOAD:   loads_in++;
          OP_ENCODE: encodes_in++;
          OP_FLUSH:  flushes_in++;
          default: ;
        endcase
        beats_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_beats.size() != 0
            && $urandom_range(99) >= sender_gap_pct(pending_beats[0].mode)
            && (!pending_beats[0].drain_first || expected_words.size() == 0)) begin
          in_beat = pending_beats.pop_front();
          in_if.valid       <= 1'b1;
          in_if.operation   <= in_beat.operation;
          in_if.symbol      <= in_beat.symbol;
          in_if.code_bits   <= in_beat.code_bits;
          in_if.code_length <= in_beat.code_length;
          traffic_mode      <= in_beat.mode;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct(traffic_mode));
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    packed_word_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_seen++;
      if (out_if.is_final === 1'b1) finals_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: word %h arrived with nothing expected", $time, out_if.packed_word);
        errors++;
      end else begin
        w = expected_words.pop_front();
        check_field("packed_word", w.packed_word, out_if.packed_word);
        check_field("byte_count", 64'(w.byte_count), 64'(out_if.byte_count));
        check_field("pad_bits", 64'(w.pad_bits), 64'(out_if.pad_bits));
        check_field("is_final", 64'(w.is_final), 64'(out_if.is_final));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.operation   = OP_LOAD;
    in_if.symbol      = '0;
    in_if.code_bits   = '0;
    in_if.code_length = '0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    acc_word          = '0;
    fill_bits         = 0;
    idle_cycles       = 0;
    errors            = 0;
    beats_in          = 0;
    beats_queued      = 0;
    loads_in          = 0;
    encodes_in        = 0;
    flushes_in        = 0;
    words_seen        = 0;
    finals_seen       = 0;
    drain_next        = 1'b0;
    gen_mode          = 0;
    foreach (loaded_map[i]) loaded_map[i] = 1'b0;

    push_beat(OP_LOAD, 8'd0, ~64'd0, 7'd64);
    push_beat(OP_LOAD, 8'd255, 64'h8000_0000_0000_0000, 7'd1);
    push_beat(OP_LOAD, 8'd1, {$urandom, $urandom}, 7'd100);
    push_beat(OP_LOAD, 8'd2, {$urandom, $urandom}, 7'd0);
    push_beat(OP_LOAD, 8'd3, 64'hA400_0000_0000_0000 | {32'd0, $urandom}, 7'd7);
    push_beat(OP_LOAD, 8'd128, 64'd0, 7'd127);
    push_beat(OP_FLUSH, 8'd0, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd255, 64'd0, 7'd0);
    push_beat(OP_FLUSH, 8'd255, ~64'd0, 7'd127);
    push_beat(OP_ENCODE, 8'd3, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd255, 64'd0, 7'd0);
    push_beat(OP_FLUSH, 8'd0, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd2, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd0, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd3, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd0, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd1, 64'd0, 7'd0);
    push_beat(OP_ENCODE, 8'd128, 64'd0, 7'd0);
    push_beat(OP_UNUSED, 8'd3, ~64'd0, 7'd5);
    push_beat(OP_ENCODE, 8'd255, 64'd0, 7'd0);
    push_beat(OP_FLUSH, 8'd0, 64'd0, 7'd0);
    push_beat(OP_LOAD, 8'd3, 64'hFFFF_0000_0000_0000, 7'd16);
    push_beat(OP_ENCODE, 8'd3, 64'd0, 7'd0);

    for (int unsigned m = 0; m < 3; m++) begin
      gen_mode   = m;
      drain_next = 1'b1;
      add_random_beats(RANDOM_PER_MODE);
    end
    push_beat(OP_FLUSH, 8'd0, 64'd0, 7'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in != beats_queued) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d beats in: %0d loads, %0d encodes, %0d flushes, rest unused ops",
             beats_in, loads_in, encodes_in, flushes_in);
    $display("checked %0d output words, %0d of them final partial words, %0d errors",
             words_seen, finals_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: huffman_code_bit_packer.f
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_if.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/huffman_code_bit_packer.sv
tb/tb_huffman_code_bit_packer.sv
